/* hdl/dclpfq_pkg.sv */
// Shared types and constants for the dual click / long press fire qualifier.
// No dependencies.
package dclpfq_pkg;

   // Per-button state machine, one-hot
   typedef enum logic [3:0] {
      CH_RELEASED = 4'b0001,
      CH_PRESSING = 4'b0010,
      CH_PENDING  = 4'b0100,
      CH_LONG     = 4'b1000
   } chan_state_type;

   // Fire state codes on the result channel
   localparam logic [1:0] FIRE_RELEASED   = 2'd0;
   localparam logic [1:0] FIRE_PRESSING   = 2'd1;
   localparam logic [1:0] FIRE_SINGLE     = 2'd2;
   localparam logic [1:0] FIRE_CONTINUOUS = 2'd3;

   // Threshold register
   localparam int unsigned THRESHOLD_W = 22;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 22'd150000;

   // Channel indexes
   localparam int unsigned NUM_CH = 2;
   localparam int unsigned CH_TRIGGER = 0;
   localparam int unsigned CH_MOUSE = 1;

endpackage

/* hdl/dual_click_long_press_fire_qualifier.sv */
// Top level: trigger / mouse button click versus long press qualifier.
// Depends on dclpfq_pkg.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | valid, ready, trigger/mouse level, now_us| in
//   rsp     | valid, ready, fire_state                | out
//   csr     | valid, ready, long_press_threshold_us   | in
//
// One item per cycle while the result register is free or being taken: both channel
// machines and the merge are combinational, from the state registers into the result register.
// req_ready is high while the result register is empty or being taken.
// A stalled result holds; no item is taken until it leaves.
// Synchronous reset: both buttons released, threshold 150000 us.
module dual_click_long_press_fire_qualifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_trigger_pressed,
   input  logic        req_mouse_pressed,
   input  logic [31:0] req_now_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_fire_state,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [dclpfq_pkg::THRESHOLD_W-1:0] csr_long_press_threshold_us
);

   dclpfq_pkg::chan_state_type state_ff [dclpfq_pkg::NUM_CH];
   dclpfq_pkg::chan_state_type step_st  [dclpfq_pkg::NUM_CH];
   dclpfq_pkg::chan_state_type state_in [dclpfq_pkg::NUM_CH];
   logic [31:0] start_ff [dclpfq_pkg::NUM_CH];
   logic [31:0] start_in [dclpfq_pkg::NUM_CH];
   logic [31:0] held_for [dclpfq_pkg::NUM_CH];
   logic        pressed  [dclpfq_pkg::NUM_CH];
   logic        is_long  [dclpfq_pkg::NUM_CH];
   logic [dclpfq_pkg::THRESHOLD_W-1:0] threshold_ff;
   logic        rsp_valid_ff;
   logic [1:0]  fire_ff;
   logic [1:0]  fire_in;
   logic        any_long;
   logic        any_single;
   logic        any_pressing;
   logic        req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fire_state = fire_ff;

   assign pressed[dclpfq_pkg::CH_TRIGGER] = req_trigger_pressed;
   assign pressed[dclpfq_pkg::CH_MOUSE]   = req_mouse_pressed;

   // Per-button step: modular duration against threshold
   always_comb begin
      for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
         held_for[ch] = req_now_us - start_ff[ch];
         is_long[ch]  = held_for[ch] >= {{(32-dclpfq_pkg::THRESHOLD_W){1'b0}}, threshold_ff};
         step_st[ch]  = state_ff[ch];
         start_in[ch] = start_ff[ch];
         case (state_ff[ch])
            dclpfq_pkg::CH_RELEASED: begin
               if (pressed[ch]) begin
                  step_st[ch]  = dclpfq_pkg::CH_PRESSING;
                  start_in[ch] = req_now_us;
               end
            end
            dclpfq_pkg::CH_PRESSING: begin
               if (!pressed[ch]) begin
                  step_st[ch] = is_long[ch] ? dclpfq_pkg::CH_LONG : dclpfq_pkg::CH_PENDING;
               end else if (is_long[ch]) begin
                  step_st[ch] = dclpfq_pkg::CH_LONG;
               end
            end
            dclpfq_pkg::CH_PENDING: begin
               step_st[ch] = dclpfq_pkg::CH_PENDING;
            end
            dclpfq_pkg::CH_LONG: begin
               if (!pressed[ch]) begin
                  step_st[ch] = dclpfq_pkg::CH_RELEASED;
               end
            end
            default: begin
               step_st[ch] = dclpfq_pkg::CH_RELEASED;
            end
         endcase
      end
   end

   // Merge: long hold wins, then pending singles are consumed, then pressing
   always_comb begin
      any_long     = 1'b0;
      any_single   = 1'b0;
      any_pressing = 1'b0;
      for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
         any_long     = any_long || (step_st[ch] == dclpfq_pkg::CH_LONG);
         any_single   = any_single || (step_st[ch] == dclpfq_pkg::CH_PENDING);
         any_pressing = any_pressing || (step_st[ch] == dclpfq_pkg::CH_PRESSING);
      end
      for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
         state_in[ch] = step_st[ch];
         if (!any_long && step_st[ch] == dclpfq_pkg::CH_PENDING) begin
            state_in[ch] = dclpfq_pkg::CH_RELEASED;
         end
      end
      if (any_long) begin
         fire_in = dclpfq_pkg::FIRE_CONTINUOUS;
      end else if (any_single) begin
         fire_in = dclpfq_pkg::FIRE_SINGLE;
      end else if (any_pressing) begin
         fire_in = dclpfq_pkg::FIRE_PRESSING;
      end else begin
         fire_in = dclpfq_pkg::FIRE_RELEASED;
      end
   end

   // Channel state and start times, updated on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
            state_ff[ch] <= dclpfq_pkg::CH_RELEASED;
            start_ff[ch] <= 32'd0;
         end
      end else if (req_xfer) begin
         for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
            state_ff[ch] <= state_in[ch];
            start_ff[ch] <= start_in[ch];
         end
      end
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= dclpfq_pkg::THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_long_press_threshold_us;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         fire_ff <= fire_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Continuous fire shown only while some button is in long hold
   a_cont_has_long: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && fire_ff == dclpfq_pkg::FIRE_CONTINUOUS) |->
      (state_ff[0] == dclpfq_pkg::CH_LONG || state_ff[1] == dclpfq_pkg::CH_LONG))
      else $error("continuous fire without a long hold");

   // A pending single survives only behind a long hold on the other button
   a_pending_held_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff[0] == dclpfq_pkg::CH_PENDING || state_ff[1] == dclpfq_pkg::CH_PENDING) |->
      (state_ff[0] == dclpfq_pkg::CH_LONG || state_ff[1] == dclpfq_pkg::CH_LONG))
      else $error("pending single not consumed");

   // A single shot always consumes every pending single
   a_single_consumed: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && fire_in == dclpfq_pkg::FIRE_SINGLE) |=>
      (state_ff[0] != dclpfq_pkg::CH_PENDING && state_ff[1] != dclpfq_pkg::CH_PENDING))
      else $error("single shot left a pending single");
`endif

endmodule

/* test/dual_click_long_press_fire_qualifier_test.sv */
`timescale 1ns / 1ps
// Testbench for the dual click / long press fire qualifier.
// It checks every fire state against a predictor under directed and random traffic.
// Depends on dclpfq_pkg and the dual_click_long_press_fire_qualifier RTL.
module dual_click_long_press_fire_qualifier_test;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned PHASE_ITEMS = 200;
   localparam int unsigned MAX_PRINTED = 20;
   localparam int unsigned TH_W = dclpfq_pkg::THRESHOLD_W;
   localparam logic [TH_W-1:0] THRESHOLD_MAX = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_trigger_pressed = 1'b0;
   logic        req_mouse_pressed = 1'b0;
   logic [31:0] req_now_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_fire_state;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [TH_W-1:0] csr_long_press_threshold_us = '0;

   // Predictor state: one machine per button plus the threshold
   dclpfq_pkg::chan_state_type chan_q[dclpfq_pkg::NUM_CH];
   logic [31:0]                start_q[dclpfq_pkg::NUM_CH];
   logic [TH_W-1:0]            threshold_q;
   logic [1:0]                 fire_expect_q[$];

   // Stimulus-side tracking used to aim timestamps at the threshold boundary
   logic        stim_level[dclpfq_pkg::NUM_CH];
   logic [31:0] stim_press_at[dclpfq_pkg::NUM_CH];
   logic [31:0] stim_now;

   bit          pace = 1'b1;
   int unsigned rsp_stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_errors = 0;
   int unsigned n_req = 0;
   int unsigned n_csr = 0;
   int unsigned fire_seen[4] = '{0, 0, 0, 0};

   always #2 clock = ~clock;

   dual_click_long_press_fire_qualifier i_dut (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_trigger_pressed         (req_trigger_pressed),
      .req_mouse_pressed           (req_mouse_pressed),
      .req_now_us                  (req_now_us),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_fire_state              (rsp_fire_state),
      .csr_valid                   (csr_valid),
      .csr_ready                   (csr_ready),
      .csr_long_press_threshold_us (csr_long_press_threshold_us)
   );

   // Idle length: mostly none, some short, a few long; none at all when pace is off
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!pace || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // One button machine for one period
   function automatic void advance_button(int unsigned ch, logic level, logic [31:0] now);
      logic [31:0] held;
      logic        held_long;
      held = now - start_q[ch];
      held_long = (held >= {10'd0, threshold_q});
      case (chan_q[ch])
         dclpfq_pkg::CH_RELEASED: begin
            if (level) begin
               chan_q[ch] = dclpfq_pkg::CH_PRESSING;
               start_q[ch] = now;
            end
         end
         dclpfq_pkg::CH_PRESSING: begin
            if (!level || held_long)
               chan_q[ch] = held_long ? dclpfq_pkg::CH_LONG : dclpfq_pkg::CH_PENDING;
         end
         dclpfq_pkg::CH_PENDING: ;
         default: begin
            if (!level) chan_q[ch] = dclpfq_pkg::CH_RELEASED;
         end
      endcase
   endfunction

   // Merge both buttons; a pending single is consumed unless a long hold wins
   function automatic logic [1:0] merge_buttons();
      logic single_seen;
      single_seen = 1'b0;
      if (chan_q[dclpfq_pkg::CH_TRIGGER] == dclpfq_pkg::CH_LONG ||
          chan_q[dclpfq_pkg::CH_MOUSE] == dclpfq_pkg::CH_LONG)
         return dclpfq_pkg::FIRE_CONTINUOUS;
      for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
         if (chan_q[ch] == dclpfq_pkg::CH_PENDING) begin
            chan_q[ch] = dclpfq_pkg::CH_RELEASED;
            single_seen = 1'b1;
         end
      end
      if (single_seen) return dclpfq_pkg::FIRE_SINGLE;
      if (chan_q[dclpfq_pkg::CH_TRIGGER] == dclpfq_pkg::CH_PRESSING ||
          chan_q[dclpfq_pkg::CH_MOUSE] == dclpfq_pkg::CH_PRESSING)
         return dclpfq_pkg::FIRE_PRESSING;
      return dclpfq_pkg::FIRE_RELEASED;
   endfunction

   task automatic report_error(input string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
   endtask

   // Drive one sample and hold it until the transfer, then idle for a random gap, which may be none
   task automatic send_sample(input logic trig, input logic mouse, input logic [31:0] now);
      int unsigned gap;
      req_valid <= 1'b1;
      req_trigger_pressed <= trig;
      req_mouse_pressed <= mouse;
      req_now_us <= now;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and let every outstanding fire state come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fire_expect_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [TH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_long_press_threshold_us <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold_q = value;
      n_csr++;
   endtask

   // Predict on every accepted sample
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         advance_button(dclpfq_pkg::CH_TRIGGER, req_trigger_pressed, req_now_us);
         advance_button(dclpfq_pkg::CH_MOUSE, req_mouse_pressed, req_now_us);
         fire_expect_q.push_back(merge_buttons());
         n_req++;
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      logic [1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fire_expect_q.size() == 0) begin
            report_error($sformatf("fire state %0d with nothing expected", rsp_fire_state));
         end else begin
            want = fire_expect_q.pop_front();
            fire_seen[want]++;
            if (rsp_fire_state !== want)
               report_error($sformatf("fire state %0d, expected %0d", rsp_fire_state, want));
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_stall_left = pick_gap();
         rsp_ready <= (rsp_stall_left == 0);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("dual_click_long_press_fire_qualifier_test: errors");
         $finish;
      end
   end

   // Clicks, holds, wrap, backwards time and a held-back single at the reset threshold
   task automatic test_click_and_hold();
      pace = 1'b1;
      send_sample(1'b0, 1'b0, 32'h0000_0000);
      // trigger held just short of, then onto, the threshold
      send_sample(1'b1, 1'b0, 32'd100);
      send_sample(1'b1, 1'b0, 32'd100 + 32'd149999);
      send_sample(1'b1, 1'b0, 32'd100 + 32'd150000);
      send_sample(1'b0, 1'b0, 32'd200000);
      // short mouse click across the timestamp wrap
      send_sample(1'b0, 1'b1, 32'hFFFF_FF00);
      send_sample(1'b0, 1'b0, 32'h0000_0010);
      // single held back behind a long trigger hold; pending ignores the level
      send_sample(1'b1, 1'b0, 32'h0001_0000);
      send_sample(1'b1, 1'b0, 32'h0001_0000 + 32'd150000);
      send_sample(1'b1, 1'b1, 32'h0004_0000);
      send_sample(1'b1, 1'b0, 32'h0004_0005);
      send_sample(1'b1, 1'b1, 32'h0004_0009);
      send_sample(1'b0, 1'b1, 32'h0004_000A);
      send_sample(1'b0, 1'b0, 32'h0004_000B);
      // timestamp going backwards looks like a very long press
      send_sample(1'b0, 1'b1, 32'd5000);
      send_sample(1'b0, 1'b1, 32'd4999);
      send_sample(1'b0, 1'b0, 32'd5001);
      // release exactly at the threshold is a long hold
      send_sample(1'b1, 1'b0, 32'h8000_0000);
      send_sample(1'b0, 1'b0, 32'h8000_0000 + 32'd150000);
      send_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
      // both buttons pressed together and released long after give continuous fire
      send_sample(1'b1, 1'b1, 32'h5555_5555);
      send_sample(1'b0, 1'b0, 32'hAAAA_AAAA);
   endtask

   // Zero threshold and the widest threshold
   task automatic test_threshold_extremes();
      pace = 1'b1;
      drain_results();
      write_threshold('0);
      send_sample(1'b1, 1'b1, 32'h1234_5678);
      send_sample(1'b1, 1'b1, 32'h1234_5678);
      send_sample(1'b0, 1'b0, 32'h1234_5679);
      drain_results();
      write_threshold(THRESHOLD_MAX);
      send_sample(1'b1, 1'b0, 32'h0000_0000);
      send_sample(1'b0, 1'b0, {10'd0, THRESHOLD_MAX} - 32'd1);
      send_sample(1'b0, 1'b1, 32'h0100_0000);
      send_sample(1'b0, 1'b1, 32'h0100_0000 + {10'd0, THRESHOLD_MAX});
      send_sample(1'b0, 1'b0, 32'h0200_0000);
   endtask

   // Button sequences with timestamps aimed around the threshold, some noise
   task automatic run_random_phase(input logic [TH_W-1:0] th);
      logic        level[dclpfq_pkg::NUM_CH];
      logic [31:0] now;
      logic [31:0] span;
      int unsigned pick;
      int unsigned ch;
      drain_results();
      write_threshold(th);
      span = {10'd0, th};
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
         if (i % 64 == 0) pace = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         ch = $urandom_range(0, 1);
         if (pick < 35)
            now = stim_press_at[ch] + span - 32'd1 + $urandom_range(0, 2);
         else if (pick < 70)
            now = stim_now + $urandom_range(0, span / 4 + 3);
         else if (pick < 82)
            now = stim_now + $urandom_range(0, span * 2 + 2);
         else if (pick < 88)
            now = stim_now;
         else if (pick < 94)
            now = stim_now - $urandom_range(1, 1000);
         else
            now = $urandom();
         stim_now = now;
         pick = $urandom_range(0, 99);
         for (int b = 0; b < dclpfq_pkg::NUM_CH; b++) begin
            if (pick < 10)
               level[b] = 1'($urandom_range(0, 1));
            else
               level[b] = stim_level[b] ^ ($urandom_range(0, 99) < 30);
            if (level[b] && !stim_level[b]) stim_press_at[b] = now;
            stim_level[b] = level[b];
         end
         send_sample(level[dclpfq_pkg::CH_TRIGGER], level[dclpfq_pkg::CH_MOUSE], now);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(TH_W'($urandom_range(1, 40)));
      run_random_phase(dclpfq_pkg::THRESHOLD_RESET);
      run_random_phase(TH_W'(4000000));
      run_random_phase('0);
      run_random_phase(TH_W'($urandom()));
      run_random_phase(TH_W'($urandom_range(2, 16)));
      run_random_phase(THRESHOLD_MAX);
   endtask

   initial begin
      for (int ch = 0; ch < dclpfq_pkg::NUM_CH; ch++) begin
         chan_q[ch] = dclpfq_pkg::CH_RELEASED;
         start_q[ch] = '0;
         stim_level[ch] = 1'b0;
         stim_press_at[ch] = '0;
      end
      threshold_q = dclpfq_pkg::THRESHOLD_RESET;
      stim_now = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_click_and_hold();
      test_threshold_extremes();
      test_random_traffic();

      drain_results();
      repeat (4) @(posedge clock);
      $display("covered %0d samples under %0d threshold settings", n_req, n_csr);
      $display("fire states seen: released %0d, pressing %0d, single %0d, continuous %0d",
               fire_seen[dclpfq_pkg::FIRE_RELEASED], fire_seen[dclpfq_pkg::FIRE_PRESSING],
               fire_seen[dclpfq_pkg::FIRE_SINGLE], fire_seen[dclpfq_pkg::FIRE_CONTINUOUS]);
      if (n_errors == 0)
         $display("dual_click_long_press_fire_qualifier_test: clean");
      else
         $display("dual_click_long_press_fire_qualifier_test: errors");
      $finish;
   end

endmodule

/* dual_click_long_press_fire_qualifier.f */
hdl/dclpfq_pkg.sv
hdl/dual_click_long_press_fire_qualifier.sv
test/dual_click_long_press_fire_qualifier_test.sv
